>>> rtl/core/rbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types, register indexes and mode decode for the RGBA blend
// compositor pipeline.
// ----------------------------------------------------------------------------
package rbc_pkg;

	localparam int CHANNEL_BITS_DEF = 16;
	localparam int FIELD_W          = 16;
	localparam int IN_FIELDS        = 9;
	localparam int CFG_IDX_W        = 2;
	localparam int MODE_CODE_W      = 3;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_SEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPACITY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_EN  = 2'd2;

	// blend mode codes as written by software
	localparam logic [MODE_CODE_W-1:0] CODE_OVER     = 3'd0;
	localparam logic [MODE_CODE_W-1:0] CODE_UNDER    = 3'd1;
	localparam logic [MODE_CODE_W-1:0] CODE_SCREEN   = 3'd2;
	localparam logic [MODE_CODE_W-1:0] CODE_MULTIPLY = 3'd3;
	localparam logic [MODE_CODE_W-1:0] CODE_ADD      = 3'd4;

	typedef enum logic [MODE_CODE_W-1:0] {
		MODE_OVER,
		MODE_UNDER,
		MODE_SCREEN,
		MODE_MULT,
		MODE_ADD
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [FIELD_W-1:0] opacity;
		logic               mask_en;
	} cfg_t;

	// unused codes fall back to over
	function automatic mode_t decode_mode(input logic [MODE_CODE_W-1:0] code);
		mode_t m;
		unique case (code)
			CODE_OVER:     m = MODE_OVER;
			CODE_UNDER:    m = MODE_UNDER;
			CODE_SCREEN:   m = MODE_SCREEN;
			CODE_MULTIPLY: m = MODE_MULT;
			CODE_ADD:      m = MODE_ADD;
			default:       m = MODE_OVER;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/rbc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbc_div
// Two-stage divide by full scale (2^N - 1) over several lanes: a
// reciprocal estimate, then one remainder check and correction. A sideband
// word rides along with the lanes.
// ----------------------------------------------------------------------------
module rbc_div
	import rbc_pkg::*;
#(
	parameter int N      = CHANNEL_BITS_DEF,
	parameter int LANES  = 4,
	parameter int SIDE_W = 16
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_vld,
	input  wire  [LANES-1:0][2*N-1:0]      in_val,
	input  wire  [SIDE_W-1:0]              in_side,
	output logic                           out_vld,
	output logic [LANES-1:0][N-1:0]        out_q,
	output logic [SIDE_W-1:0]              out_side
);

	localparam logic [2*N:0] FULL_W = (2*N+1)'((1 << N) - 1);

	logic                       vld_s1;
	logic [LANES-1:0][2*N-1:0]  val_s1;
	logic [LANES-1:0][N:0]      est_s1;
	logic [SIDE_W-1:0]          side_s1;
	logic [LANES-1:0][N:0]      est_c;
	logic [LANES-1:0][N-1:0]    q_c;

	// v/(2^N-1) is close to (v + v/2^N)/2^N and never below it
	always_comb begin
		logic [2*N:0] sum;
		for (int i = 0; i < LANES; i++) begin
			sum      = {1'b0, in_val[i]} + (2*N+1)'(in_val[i] >> N);
			est_c[i] = sum[2*N:N];
		end
	end

	// the estimate is low by at most one: check the remainder once
	always_comb begin
		logic [2*N:0] rem;
		logic [N:0]   q;
		for (int i = 0; i < LANES; i++) begin
			rem = {1'b0, val_s1[i]} + (2*N+1)'(est_s1[i])
				- ((2*N+1)'(est_s1[i]) << N);
			q = est_s1[i] + (N+1)'(rem >= FULL_W);
			q_c[i] = q[N-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		val_s1   <= in_val;
		est_s1   <= est_c;
		side_s1  <= in_side;
		out_q    <= q_c;
		out_side <= side_s1;
	end

endmodule
`default_nettype wire

>>> rtl/core/rbc_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbc_prep
// Front of the pipeline: clamp the input channels to full scale, pick front
// and back pixel by mode, then form the first product on each lane
// (effective alpha, screen/multiply mix, or add-mode scaled background).
// ----------------------------------------------------------------------------
module rbc_prep
	import rbc_pkg::*;
#(
	parameter int N = CHANNEL_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  cfg_t                                cfg,
	input  wire                                 in_vld,
	input  wire  [IN_FIELDS-1:0][FIELD_W-1:0]   in_fld,
	output logic                                out_vld,
	output logic [3:0][2*N-1:0]                 out_val,
	output logic [9*N-1:0]                      out_side
);

	localparam logic [FIELD_W-1:0] FULL_F = FIELD_W'((1 << N) - 1);
	localparam logic [N-1:0]       FULL_N = N'((1 << N) - 1);
	localparam logic [2*N-1:0]     HALF   = (2*N)'(((1 << N) - 1) >> 1);

	logic [IN_FIELDS-1:0][N-1:0] clip_c;
	logic [3:0][N-1:0]           frt_c;
	logic [3:0][N-1:0]           bak_c;
	logic                        vld_s1;
	logic [3:0][N-1:0]           frt_s1;
	logic [3:0][N-1:0]           bak_s1;
	logic [N-1:0]                msk_s1;
	logic [N-1:0]                op_c;
	logic [3:0][2*N-1:0]         val_c;

	always_comb begin
		for (int i = 0; i < IN_FIELDS; i++) begin
			clip_c[i] = (in_fld[i] > FULL_F) ? FULL_N : in_fld[i][N-1:0];
		end
		for (int i = 0; i < 4; i++) begin
			if (cfg.mode == MODE_UNDER) begin
				frt_c[i] = clip_c[4+i];
				bak_c[i] = clip_c[i];
			end else begin
				frt_c[i] = clip_c[i];
				bak_c[i] = clip_c[4+i];
			end
		end
	end

	assign op_c = (cfg.opacity > FULL_F) ? FULL_N : cfg.opacity[N-1:0];

	always_comb begin
		logic [N-1:0] x;
		logic [N-1:0] y;
		for (int i = 0; i < 3; i++) begin
			case (cfg.mode)
				MODE_ADD: begin
					x = bak_s1[i];
					y = op_c;
				end
				MODE_SCREEN: begin
					x = FULL_N - frt_s1[i];
					y = FULL_N - bak_s1[i];
				end
				default: begin
					x = frt_s1[i];
					y = bak_s1[i];
				end
			endcase
			val_c[i] = (2*N)'(x) * (2*N)'(y) + HALF;
		end
		// alpha lane: effective alpha, or scaled background alpha in add mode
		x = (cfg.mode == MODE_ADD) ? bak_s1[3] : frt_s1[3];
		val_c[3] = (2*N)'(x) * (2*N)'(op_c) + HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		frt_s1   <= frt_c;
		bak_s1   <= bak_c;
		msk_s1   <= clip_c[8];
		out_val  <= val_c;
		out_side <= {msk_s1, bak_s1, frt_s1};
	end

endmodule
`default_nettype wire

>>> rtl/core/rbc_lerp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbc_lerp
// Middle stage: finish add mode with saturation, and form the blend sums
// mix*alpha + back*(1-alpha) for colour and back_alpha*(1-alpha) for alpha.
// ----------------------------------------------------------------------------
module rbc_lerp
	import rbc_pkg::*;
#(
	parameter int N = CHANNEL_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  cfg_t                        cfg,
	input  wire                         in_vld,
	input  wire  [3:0][N-1:0]           in_q,
	input  wire  [9*N-1:0]              in_side,
	output logic                        out_vld,
	output logic [3:0][2*N-1:0]         out_val,
	output logic [6*N-1:0]              out_side
);

	localparam logic [N-1:0]   FULL_N = N'((1 << N) - 1);
	localparam logic [N:0]     FULL_X = (N+1)'((1 << N) - 1);
	localparam logic [2*N-1:0] HALF   = (2*N)'(((1 << N) - 1) >> 1);

	logic [3:0][N-1:0]   frt;
	logic [3:0][N-1:0]   bak;
	logic [N-1:0]        msk;
	logic [N-1:0]        alpha;
	logic [N-1:0]        inv;
	logic [3:0][N-1:0]   add_c;
	logic [3:0][2*N-1:0] val_c;

	assign frt   = in_side[4*N-1:0];
	assign bak   = in_side[8*N-1:4*N];
	assign msk   = in_side[9*N-1:8*N];
	assign alpha = in_q[3];
	assign inv   = FULL_N - alpha;

	always_comb begin
		logic [N:0]   sum;
		logic [N-1:0] mix;
		for (int i = 0; i < 4; i++) begin
			sum      = {1'b0, frt[i]} + {1'b0, in_q[i]};
			add_c[i] = (sum > FULL_X) ? FULL_N : sum[N-1:0];
		end
		for (int i = 0; i < 3; i++) begin
			case (cfg.mode)
				MODE_SCREEN: mix = FULL_N - in_q[i];
				MODE_MULT:   mix = in_q[i];
				default:     mix = frt[i];
			endcase
			val_c[i] = (2*N)'(mix) * (2*N)'(alpha) + (2*N)'(bak[i]) * (2*N)'(inv) + HALF;
		end
		val_c[3] = (2*N)'(bak[3]) * (2*N)'(inv) + HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		out_val  <= val_c;
		out_side <= {msk, alpha, add_c};
	end

endmodule
`default_nettype wire

>>> rtl/core/rbc_mask.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbc_mask
// Late stage: settle the four result channels and form the mask product
// on the output alpha.
// ----------------------------------------------------------------------------
module rbc_mask
	import rbc_pkg::*;
#(
	parameter int N = CHANNEL_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  cfg_t                        cfg,
	input  wire                         in_vld,
	input  wire  [3:0][N-1:0]           in_q,
	input  wire  [6*N-1:0]              in_side,
	output logic                        out_vld,
	output logic [0:0][2*N-1:0]         out_val,
	output logic [4*N-1:0]              out_side
);

	localparam logic [N-1:0]   FULL_N = N'((1 << N) - 1);
	localparam logic [N:0]     FULL_X = (N+1)'((1 << N) - 1);
	localparam logic [2*N-1:0] HALF   = (2*N)'(((1 << N) - 1) >> 1);

	logic [3:0][N-1:0] add_res;
	logic [N-1:0]      alpha;
	logic [N-1:0]      msk;
	logic [3:0][N-1:0] res_c;
	logic [N:0]        a_sum;

	assign add_res = in_side[4*N-1:0];
	assign alpha   = in_side[5*N-1:4*N];
	assign msk     = in_side[6*N-1:5*N];
	assign a_sum   = {1'b0, alpha} + {1'b0, in_q[3]};

	always_comb begin
		if (cfg.mode == MODE_ADD) begin
			res_c = add_res;
		end else begin
			for (int i = 0; i < 3; i++) begin
				res_c[i] = in_q[i];
			end
			res_c[3] = (a_sum > FULL_X) ? FULL_N : a_sum[N-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		out_val[0] <= (2*N)'(res_c[3]) * (2*N)'(msk) + HALF;
		out_side   <= res_c;
	end

endmodule
`default_nettype wire

>>> rtl/core/rgba_blend_compositor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_blend_compositor
// Per-pixel compositor of a foreground and a background RGBA pixel.
//
// Pixel channel: a beat is taken at each rising edge with start high and
// busy low. Each beat carries both pixels and a mask sample. The composited
// pixel sits on out_* for one cycle with done high; the result channel has no
// back-pressure. Throughput is one pixel per cycle: a fully pipelined 11-stage
// datapath with three divide-by-full-scale units, each following one of the
// multiply stages.
// Configuration: write the mode (0), opacity (1) or mask enable (2) through
// cfg_valid/cfg_ready with cfg_index and cfg_data; write only with no pixel
// in flight. Index 3 is ignored.
// Reset: all valid bits clear, registers return to over, full opacity, no
// mask; busy stays high for the first cycle after reset release.
// ----------------------------------------------------------------------------
module rgba_blend_compositor
	import rbc_pkg::*;
#(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  wire  [FIELD_W-1:0]     fg_red,
	input  wire  [FIELD_W-1:0]     fg_green,
	input  wire  [FIELD_W-1:0]     fg_blue,
	input  wire  [FIELD_W-1:0]     fg_alpha,
	input  wire  [FIELD_W-1:0]     bg_red,
	input  wire  [FIELD_W-1:0]     bg_green,
	input  wire  [FIELD_W-1:0]     bg_blue,
	input  wire  [FIELD_W-1:0]     bg_alpha,
	input  wire  [FIELD_W-1:0]     mask_sample,
	output logic                   done,
	output logic [FIELD_W-1:0]     out_red,
	output logic [FIELD_W-1:0]     out_green,
	output logic [FIELD_W-1:0]     out_blue,
	output logic [FIELD_W-1:0]     out_alpha,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [CFG_IDX_W-1:0]   cfg_index,
	input  wire  [FIELD_W-1:0]     cfg_data
);

	localparam int N       = CHANNEL_BITS;
	localparam int LATENCY = 11;
	localparam logic [FIELD_W-1:0] FULL_F = FIELD_W'((1 << N) - 1);

	logic                             rst_done_q;
	cfg_t                             cfg_q;
	logic                             in_acc;
	logic [IN_FIELDS-1:0][FIELD_W-1:0] in_fld;

	logic                       prep_vld;
	logic [3:0][2*N-1:0]        prep_val;
	logic [9*N-1:0]             prep_side;
	logic                       div1_vld;
	logic [3:0][N-1:0]          div1_q;
	logic [9*N-1:0]             div1_side;
	logic                       lerp_vld;
	logic [3:0][2*N-1:0]        lerp_val;
	logic [6*N-1:0]             lerp_side;
	logic                       div2_vld;
	logic [3:0][N-1:0]          div2_q;
	logic [6*N-1:0]             div2_side;
	logic                       mask_vld;
	logic [0:0][2*N-1:0]        mask_val;
	logic [4*N-1:0]             mask_side;
	logic                       div3_vld;
	logic [0:0][N-1:0]          div3_q;
	logic [3:0][N-1:0]          res;

	assign busy      = !rst_done_q;
	assign cfg_ready = rst_done_q;
	assign in_acc    = start && !busy;
	assign in_fld    = {mask_sample, bg_alpha, bg_blue, bg_green, bg_red,
		fg_alpha, fg_blue, fg_green, fg_red};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_done_q     <= 1'b0;
			cfg_q.mode     <= MODE_OVER;
			cfg_q.opacity  <= '1;
			cfg_q.mask_en  <= 1'b0;
		end else begin
			rst_done_q <= 1'b1;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_MODE_SEL: cfg_q.mode    <= decode_mode(cfg_data[MODE_CODE_W-1:0]);
					CFG_OPACITY:  cfg_q.opacity <= cfg_data;
					CFG_MASK_EN:  cfg_q.mask_en <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	rbc_prep #(.N(N)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_vld   (in_acc),
		.in_fld   (in_fld),
		.out_vld  (prep_vld),
		.out_val  (prep_val),
		.out_side (prep_side)
	);

	rbc_div #(.N(N), .LANES(4), .SIDE_W(9*N)) u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (prep_vld),
		.in_val   (prep_val),
		.in_side  (prep_side),
		.out_vld  (div1_vld),
		.out_q    (div1_q),
		.out_side (div1_side)
	);

	rbc_lerp #(.N(N)) u_lerp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_vld   (div1_vld),
		.in_q     (div1_q),
		.in_side  (div1_side),
		.out_vld  (lerp_vld),
		.out_val  (lerp_val),
		.out_side (lerp_side)
	);

	rbc_div #(.N(N), .LANES(4), .SIDE_W(6*N)) u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (lerp_vld),
		.in_val   (lerp_val),
		.in_side  (lerp_side),
		.out_vld  (div2_vld),
		.out_q    (div2_q),
		.out_side (div2_side)
	);

	rbc_mask #(.N(N)) u_mask (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_vld   (div2_vld),
		.in_q     (div2_q),
		.in_side  (div2_side),
		.out_vld  (mask_vld),
		.out_val  (mask_val),
		.out_side (mask_side)
	);

	rbc_div #(.N(N), .LANES(1), .SIDE_W(4*N)) u_div3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (mask_vld),
		.in_val   (mask_val),
		.in_side  (mask_side),
		.out_vld  (div3_vld),
		.out_q    (div3_q),
		.out_side (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div3_vld;
		end
	end

	// drop the mask product when the mask is off
	always_ff @(posedge clk) begin
		out_red   <= FIELD_W'(res[0]);
		out_green <= FIELD_W'(res[1]);
		out_blue  <= FIELD_W'(res[2]);
		out_alpha <= cfg_q.mask_en ? FIELD_W'(div3_q[0]) : FIELD_W'(res[3]);
	end

`ifndef ASSERT_OFF
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> ##LATENCY done)
		else $error("accepted pixel did not complete on time");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(in_acc, LATENCY))
		else $error("result strobe without a matching accepted pixel");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_red <= FULL_F && out_green <= FULL_F &&
			out_blue <= FULL_F && out_alpha <= FULL_F))
		else $error("result channel above full scale");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose outside reset");
`endif

endmodule
`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGBA blend compositor. Each pixel taken by
// the block is passed through a bit-exact software compositor, and the
// composited pixels seen on the done strobe are compared with it in order.
// A short directed sweep covers every mode code with corner pixels. Random
// phases then follow, each with its own mode, opacity and mask setting,
// bursty pixel traffic, and a drain before the next register change.
// ----------------------------------------------------------------------------
module testbench;
	import rbc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [FIELD_W-1:0]   FULL       = 16'hFFFF;
	localparam longint unsigned      UNIT       = 65535;
	localparam longint unsigned      HALF_UNIT  = UNIT / 2;
	localparam int                   LATENCY    = 11;
	localparam int                   PHASES     = 19;
	localparam int                   PHASE_PIXELS = 100;

	typedef struct packed {
		logic [FIELD_W-1:0] fg_red;
		logic [FIELD_W-1:0] fg_green;
		logic [FIELD_W-1:0] fg_blue;
		logic [FIELD_W-1:0] fg_alpha;
		logic [FIELD_W-1:0] bg_red;
		logic [FIELD_W-1:0] bg_green;
		logic [FIELD_W-1:0] bg_blue;
		logic [FIELD_W-1:0] bg_alpha;
		logic [FIELD_W-1:0] mask_sample;
	} pixel_pair_t;

	typedef struct packed {
		logic [FIELD_W-1:0] red;
		logic [FIELD_W-1:0] green;
		logic [FIELD_W-1:0] blue;
		logic [FIELD_W-1:0] alpha;
	} rgba_t;

	class blend_scoreboard;
		logic [MODE_CODE_W-1:0] mode_code;
		logic [FIELD_W-1:0]     opacity;
		logic                   mask_on;
		rgba_t                  expected_pixels[$];
		int                     mismatches;
		int                     pixels_checked;

		function new();
			mode_code      = CODE_OVER;
			opacity        = FULL;
			mask_on        = 1'b0;
			mismatches     = 0;
			pixels_checked = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
			case (idx)
				CFG_MODE_SEL: mode_code = data[MODE_CODE_W-1:0];
				CFG_OPACITY:  opacity   = data;
				CFG_MASK_EN:  mask_on   = data[0];
				default:      ;
			endcase
		endfunction

		// x*y/UNIT, rounded half up
		function longint unsigned unit_mul(longint unsigned x, longint unsigned y);
			return (x * y + HALF_UNIT) / UNIT;
		endfunction

		function longint unsigned clip_unit(longint unsigned v);
			return (v > UNIT) ? UNIT : v;
		endfunction

		function rgba_t composite_pixel(pixel_pair_t p);
			longint unsigned fg[4];
			longint unsigned bg[4];
			longint unsigned front[4];
			longint unsigned back[4];
			longint unsigned res[4];
			longint unsigned alpha;
			longint unsigned mix;
			rgba_t r;
			fg[0] = p.fg_red;  fg[1] = p.fg_green;  fg[2] = p.fg_blue;  fg[3] = p.fg_alpha;
			bg[0] = p.bg_red;  bg[1] = p.bg_green;  bg[2] = p.bg_blue;  bg[3] = p.bg_alpha;
			if (mode_code == CODE_ADD) begin
				for (int i = 0; i < 4; i++)
					res[i] = clip_unit(fg[i] + unit_mul(bg[i], opacity));
			end else begin
				// under swaps the roles of the two pixels
				for (int i = 0; i < 4; i++) begin
					front[i] = (mode_code == CODE_UNDER) ? bg[i] : fg[i];
					back[i]  = (mode_code == CODE_UNDER) ? fg[i] : bg[i];
				end
				alpha = unit_mul(front[3], opacity);
				for (int i = 0; i < 3; i++) begin
					case (mode_code)
						CODE_SCREEN:   mix = UNIT - unit_mul(UNIT - front[i], UNIT - back[i]);
						CODE_MULTIPLY: mix = unit_mul(front[i], back[i]);
						default:       mix = front[i];
					endcase
					res[i] = clip_unit((mix * alpha + back[i] * (UNIT - alpha) + HALF_UNIT)
						/ UNIT);
				end
				res[3] = clip_unit(alpha + unit_mul(back[3], UNIT - alpha));
			end
			if (mask_on)
				res[3] = unit_mul(res[3], p.mask_sample);
			r.red   = FIELD_W'(res[0]);
			r.green = FIELD_W'(res[1]);
			r.blue  = FIELD_W'(res[2]);
			r.alpha = FIELD_W'(res[3]);
			return r;
		endfunction

		function void note_pixel(pixel_pair_t p);
			expected_pixels.push_back(composite_pixel(p));
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		function void compare_field(string name, logic [FIELD_W-1:0] want,
				logic [FIELD_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %h, got %h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_pixel(rgba_t got);
			rgba_t want;
			if (expected_pixels.size() == 0) begin
				$error("composited pixel %h with no pixel outstanding", got);
				mismatches++;
				return;
			end
			want = expected_pixels.pop_front();
			pixels_checked++;
			compare_field("out_red",   want.red,   got.red);
			compare_field("out_green", want.green, got.green);
			compare_field("out_blue",  want.blue,  got.blue);
			compare_field("out_alpha", want.alpha, got.alpha);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [FIELD_W-1:0]     fg_red, fg_green, fg_blue, fg_alpha;
	logic [FIELD_W-1:0]     bg_red, bg_green, bg_blue, bg_alpha;
	logic [FIELD_W-1:0]     mask_sample;
	logic                   done;
	logic [FIELD_W-1:0]     out_red, out_green, out_blue, out_alpha;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [FIELD_W-1:0]     cfg_data;

	blend_scoreboard blend_sb;
	int              reg_writes;

	rgba_blend_compositor u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.fg_red      (fg_red),
		.fg_green    (fg_green),
		.fg_blue     (fg_blue),
		.fg_alpha    (fg_alpha),
		.bg_red      (bg_red),
		.bg_green    (bg_green),
		.bg_blue     (bg_blue),
		.bg_alpha    (bg_alpha),
		.mask_sample (mask_sample),
		.done        (done),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.out_alpha   (out_alpha),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 200000);
		$display("TB_ERROR");
		$finish;
	end

	// results cannot be held off: take every strobed beat
	always @(posedge clk) begin
		if (done === 1'b1)
			blend_sb.check_pixel('{out_red, out_green, out_blue, out_alpha});
	end

	// biased toward the ends of the range, where rounding and saturation bite
	function automatic logic [FIELD_W-1:0] rand_channel();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return FULL;
			2:       return FIELD_W'($urandom_range(0, 255));
			3:       return FULL - FIELD_W'($urandom_range(0, 255));
			default: return FIELD_W'($urandom);
		endcase
	endfunction

	function automatic pixel_pair_t random_pixel();
		pixel_pair_t p;
		p.fg_red      = rand_channel();
		p.fg_green    = rand_channel();
		p.fg_blue     = rand_channel();
		p.fg_alpha    = rand_channel();
		p.bg_red      = rand_channel();
		p.bg_green    = rand_channel();
		p.bg_blue     = rand_channel();
		p.bg_alpha    = rand_channel();
		p.mask_sample = rand_channel();
		return p;
	endfunction

	function automatic pixel_pair_t corner_pixel(int k);
		pixel_pair_t p;
		case (k)
			0:       p = '0;
			1:       p = '1;
			default: p = {{4{FULL}}, {4{16'h0000}}, 16'h8000};
		endcase
		return p;
	endfunction

	// write one register; the channel is touched only with nothing in flight
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		blend_sb.write_reg(idx, data);
		reg_writes++;
	endtask

	// hold start high until the beat is taken; leave it high for the next one
	task automatic drive_pixel(input pixel_pair_t p);
		fg_red      <= p.fg_red;
		fg_green    <= p.fg_green;
		fg_blue     <= p.fg_blue;
		fg_alpha    <= p.fg_alpha;
		bg_red      <= p.bg_red;
		bg_green    <= p.bg_green;
		bg_blue     <= p.bg_blue;
		bg_alpha    <= p.bg_alpha;
		mask_sample <= p.mask_sample;
		start       <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		blend_sb.note_pixel(p);
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// always advance at least one edge so back-to-back calls never collide
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (blend_sb.pending() != 0);
	endtask

	initial begin
		logic [FIELD_W-1:0] opacity_val;
		int                 sent;
		int                 burst;

		blend_sb    = new();
		reg_writes  = 0;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		fg_red      <= '0;
		fg_green    <= '0;
		fg_blue     <= '0;
		fg_alpha    <= '0;
		bg_red      <= '0;
		bg_green    <= '0;
		bg_blue     <= '0;
		bg_alpha    <= '0;
		mask_sample <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= CFG_MODE_SEL;
		cfg_data    <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// an out-of-range index must leave the mode at over
		write_reg(CFG_UNUSED, {13'h0, CODE_ADD});
		for (int code = 0; code < 8; code++) begin
			write_reg(CFG_MODE_SEL, FIELD_W'(code));
			write_reg(CFG_MASK_EN, FIELD_W'(code % 2));
			for (int k = 0; k < 3; k++)
				drive_pixel(corner_pixel(k));
			drain();
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       opacity_val = '0;
				1:       opacity_val = FULL;
				2:       opacity_val = 16'h0001;
				default: opacity_val = rand_channel();
			endcase
			write_reg(CFG_OPACITY, opacity_val);
			// upper data bits are don't-care for the narrow registers
			write_reg(CFG_MODE_SEL, {13'($urandom),
				(phase < 8) ? MODE_CODE_W'(phase) : MODE_CODE_W'($urandom_range(0, 7))});
			write_reg(CFG_MASK_EN, {15'($urandom), 1'($urandom)});
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_UNUSED, FIELD_W'($urandom));
			sent = 0;
			while (sent < PHASE_PIXELS) begin
				burst = $urandom_range(1, 24);
				if (burst > PHASE_PIXELS - sent)
					burst = PHASE_PIXELS - sent;
				for (int i = 0; i < burst; i++) begin
					drive_pixel(random_pixel());
					sent++;
				end
				case ($urandom_range(0, 9))
					0:          drain();
					1, 2, 3:    ;
					default:    pause($urandom_range(1, 8));
				endcase
			end
			drain();
		end

		drain();
		repeat (2 * LATENCY) @(posedge clk);
		$display("covered: %0d pixels composited across all eight mode codes,",
			blend_sb.pixels_checked);
		$display("  %0d register writes incl. opacity extremes and mask on/off",
			reg_writes);
		if (blend_sb.mismatches == 0 && blend_sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/rbc_pkg.sv
rtl/core/rbc_div.sv
rtl/core/rbc_prep.sv
rtl/core/rbc_lerp.sv
rtl/core/rbc_mask.sv
rtl/core/rgba_blend_compositor.sv
verif/testbench.sv
